// ----- design/c3br_pkg.sv -----
package c3br_pkg;

   localparam int DEF_MAX_WIDTH    = 64;
   localparam int DEF_MAX_HEIGHT   = 64;
   localparam int DEF_MAX_CHANNELS = 8;
   localparam int DEF_MAX_KERNELS  = 16;
   localparam int DEF_DATA_BITS    = 16;
   localparam int DEF_FRAC_BITS    = 8;

   // fixed field widths
   localparam int CFG_BITS  = 7;
   localparam int CSR_IDX_BITS = 2;
   localparam int POS_BITS  = 6;
   localparam int KSEL_BITS = 4;
   localparam int CSEL_BITS = 3;
   localparam int TAP_BITS  = 2;
   localparam int CMD_BITS  = 2;

   localparam int REQ_FIXED_BITS = 2 * TAP_BITS + CSEL_BITS + KSEL_BITS;
   localparam int RSP_FIXED_BITS = 2 * POS_BITS + KSEL_BITS;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_WEIGHT  = 2'd0,
      CMD_BIAS    = 2'd1,
      CMD_SAMPLE  = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_HEIGHT   = 2'd0,
      REG_WIDTH    = 2'd1,
      REG_CHANNELS = 2'd2,
      REG_KERNELS  = 2'd3
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   function automatic int bytes_up(input int bits);
      return ((bits + 7) / 8) * 8;
   endfunction

endpackage

// ----- design/c3br_ram.sv -----
module c3br_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic [WIDTH-1:0]                            rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/conv3x3_bias_relu_stream_unit.sv -----
// channel | handshake              | payload
// req     | req_tvalid/req_tready  | tuser: command; tdata: tap_row, tap_col, chan_index,
//         |                        |   kern_index, data_value
// rsp     | rsp_tvalid/rsp_tready  | tdata: out_row, out_col, out_kernel, out_value;
//         |                        |   tlast: last
// csr     | csr_we                 | csr_index, csr_wdata
// Weight, bias, restart and non-final channel samples are handled in ST_IDLE. A sample that
// completes a pixel at row and column >= 2 runs the single MAC over 9 x channels taps
// per kernel, passing through ST_RUN, ST_DRAIN and ST_EMIT for each kernel in turn;
// ST_EMIT waits on rsp_tready, and req_tready stays low until the last kernel is emitted.
// After reset the line store is swept to zero in ST_CLEAR, with req_tready low. The
// result register lets a new item in while a result waits.
module conv3x3_bias_relu_stream_unit #(
   parameter int MAX_WIDTH    = c3br_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT   = c3br_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_CHANNELS = c3br_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_KERNELS  = c3br_pkg::DEF_MAX_KERNELS,
   parameter int DATA_BITS    = c3br_pkg::DEF_DATA_BITS,
   parameter int FRAC_BITS    = c3br_pkg::DEF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // command
   input  logic [c3br_pkg::CMD_BITS-1:0] req_tuser,
   // tap_row, tap_col, chan_index, kern_index, data_value
   input  logic [c3br_pkg::bytes_up(c3br_pkg::REQ_FIXED_BITS + DATA_BITS)-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_row, out_col, out_kernel, out_value
   output logic [c3br_pkg::bytes_up(c3br_pkg::RSP_FIXED_BITS + DATA_BITS - 1)-1:0] rsp_tdata,
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [c3br_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [c3br_pkg::CFG_BITS-1:0] csr_wdata
);
   import c3br_pkg::*;

   localparam int RW  = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW  = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
   localparam int XW  = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
   localparam int KW  = MAX_KERNELS > 1 ? $clog2(MAX_KERNELS) : 1;
   localparam int HCW = $clog2(MAX_HEIGHT + 1);
   localparam int WCW = $clog2(MAX_WIDTH + 1);
   localparam int XCW = $clog2(MAX_CHANNELS + 1);
   localparam int KCW = $clog2(MAX_KERNELS + 1);
   localparam int LINE_DEPTH = 3 * MAX_WIDTH * MAX_CHANNELS;
   localparam int WGT_DEPTH  = 9 * MAX_CHANNELS * MAX_KERNELS;
   localparam int LAW = LINE_DEPTH > 1 ? $clog2(LINE_DEPTH) : 1;
   localparam int WAW = WGT_DEPTH > 1 ? $clog2(WGT_DEPTH) : 1;
   localparam int PW  = 2 * DATA_BITS;
   localparam int ACCW = PW + FRAC_BITS + $clog2(9 * MAX_CHANNELS + 1) + 2;
   localparam int VW  = DATA_BITS - 1;
   localparam int REQW = bytes_up(REQ_FIXED_BITS + DATA_BITS);
   localparam int RSPW = bytes_up(RSP_FIXED_BITS + VW);

   // request fields
   cmd_type                cmd;
   logic [TAP_BITS-1:0]    f_row, f_col;
   logic [CSEL_BITS-1:0]   f_chan;
   logic [KSEL_BITS-1:0]   f_kern;
   logic [DATA_BITS-1:0]   f_data;

   assign cmd    = cmd_type'(req_tuser);
   assign f_row  = req_tdata[1:0];
   assign f_col  = req_tdata[3:2];
   assign f_chan = req_tdata[6:4];
   assign f_kern = req_tdata[10:7];
   assign f_data = req_tdata[REQ_FIXED_BITS +: DATA_BITS];

   // configuration
   logic [CFG_BITS-1:0] height_ff, width_ff, chans_ff, kerns_ff;
   logic [HCW-1:0] hc;
   logic [WCW-1:0] wc;
   logic [XCW-1:0] xc;
   logic [KCW-1:0] kc;

   always_comb begin
      if (32'(height_ff) < 3) hc = HCW'(3);
      else if (32'(height_ff) > MAX_HEIGHT) hc = HCW'(MAX_HEIGHT);
      else hc = HCW'(height_ff);
      if (32'(width_ff) < 3) wc = WCW'(3);
      else if (32'(width_ff) > MAX_WIDTH) wc = WCW'(MAX_WIDTH);
      else wc = WCW'(width_ff);
      if (32'(chans_ff) < 1) xc = XCW'(1);
      else if (32'(chans_ff) > MAX_CHANNELS) xc = XCW'(MAX_CHANNELS);
      else xc = XCW'(chans_ff);
      if (32'(kerns_ff) < 1) kc = KCW'(1);
      else if (32'(kerns_ff) > MAX_KERNELS) kc = KCW'(MAX_KERNELS);
      else kc = KCW'(kerns_ff);
   end

   // state
   state_type state_ff, state_in;
   logic [LAW-1:0] clr_ff, clr_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [XW-1:0] chan_ff, chan_in;
   logic [1:0]    rm_ff, rm_in;        // row mod 3
   logic [KW-1:0] k_ff, k_in;
   logic [1:0]    tr_ff, tr_in, tc_ff, tc_in, lr_ff, lr_in;
   logic [XW-1:0] tx_ff, tx_in;
   logic [1:0]    blr_ff, blr_in;
   logic [CW-1:0] bcol_ff, bcol_in;
   logic [RW-1:0] orow_ff, orow_in;
   logic v1_ff, v1_in, v2_ff, v2_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSPW-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_last_ff, rsp_last_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff;
   logic [DATA_BITS-1:0] bias_ff [MAX_KERNELS];

   // memories
   logic line_we, wgt_we, issue;
   logic [LAW-1:0] line_waddr, line_raddr;
   logic [DATA_BITS-1:0] line_wdata, line_rdata, wgt_rdata;
   logic [WAW-1:0] wgt_waddr, wgt_raddr;

   c3br_ram #(.WIDTH(DATA_BITS), .DEPTH(LINE_DEPTH)) u_line (
      .clock(clock), .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
      .raddr(line_raddr), .rdata(line_rdata)
   );
   c3br_ram #(.WIDTH(DATA_BITS), .DEPTH(WGT_DEPTH)) u_wgt (
      .clock(clock), .we(wgt_we), .waddr(wgt_waddr), .wdata(f_data),
      .raddr(wgt_raddr), .rdata(wgt_rdata)
   );

   logic accept, out_free, last_tap;
   logic signed [ACCW-1:0] bias_next, shifted;
   logic [VW-1:0] res;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign last_tap = (tr_ff == 2'd2) && (tc_ff == 2'd2) && (32'(tx_ff) + 1 >= 32'(xc));

   assign wgt_we = accept && cmd == CMD_WEIGHT && f_row < 2'd3 && f_col < 2'd3
                   && 32'(f_chan) < MAX_CHANNELS && 32'(f_kern) < MAX_KERNELS;
   assign wgt_waddr = WAW'(((32'(f_row) * 3 + 32'(f_col)) * MAX_CHANNELS + 32'(f_chan))
                           * MAX_KERNELS + 32'(f_kern));
   assign wgt_raddr = WAW'(((32'(tr_ff) * 3 + 32'(tc_ff)) * MAX_CHANNELS + 32'(tx_ff))
                           * MAX_KERNELS + 32'(k_ff));
   assign line_raddr = LAW'((32'(lr_ff) * MAX_WIDTH + 32'(bcol_ff) + 32'(tc_ff))
                            * MAX_CHANNELS + 32'(tx_ff));
   assign issue = (state_ff == ST_RUN);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         line_we    = 1'b1;
         line_waddr = clr_ff;
         line_wdata = '0;
      end else begin
         line_we    = accept && cmd == CMD_SAMPLE;
         line_waddr = LAW'((32'(rm_ff) * MAX_WIDTH + 32'(col_ff)) * MAX_CHANNELS
                           + 32'(chan_ff));
         line_wdata = f_data;
      end
   end

   // result: floor to Q format, clamp at zero, saturate
   always_comb begin
      shifted = acc_ff >>> FRAC_BITS;
      if (acc_ff[ACCW-1]) res = '0;
      else if (|shifted[ACCW-1:VW]) res = '1;
      else res = shifted[VW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      row_in = row_ff; col_in = col_ff; chan_in = chan_ff; rm_in = rm_ff;
      k_in = k_ff; tr_in = tr_ff; tc_in = tc_ff; tx_in = tx_ff; lr_in = lr_ff;
      blr_in = blr_ff; bcol_in = bcol_ff; orow_in = orow_ff;
      v1_in = issue;
      v2_in = v1_ff;
      acc_in = v2_ff ? acc_ff + ACCW'(prod_ff) : acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      bias_next = ACCW'($signed(bias_ff[0])) <<< FRAC_BITS;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == LINE_DEPTH - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_RESTART: begin
                     row_in = '0; col_in = '0; chan_in = '0; rm_in = '0;
                  end
                  CMD_SAMPLE: begin
                     if (32'(chan_ff) + 1 < 32'(xc)) begin
                        chan_in = chan_ff + 1'b1;
                     end else begin
                        chan_in = '0;
                        if (32'(col_ff) + 1 < 32'(wc)) begin
                           col_in = col_ff + 1'b1;
                        end else begin
                           col_in = '0;
                           if (32'(row_ff) + 1 < 32'(hc)) begin
                              row_in = row_ff + 1'b1;
                              rm_in  = (rm_ff == 2'd2) ? 2'd0 : rm_ff + 2'd1;
                           end else begin
                              row_in = '0;
                              rm_in  = '0;
                           end
                        end
                        if (row_ff >= RW'(2) && col_ff >= CW'(2)) begin
                           blr_in  = (rm_ff == 2'd2) ? 2'd0 : rm_ff + 2'd1;
                           lr_in   = (rm_ff == 2'd2) ? 2'd0 : rm_ff + 2'd1;
                           bcol_in = col_ff - CW'(2);
                           orow_in = row_ff - RW'(2);
                           k_in = '0; tr_in = '0; tc_in = '0; tx_in = '0;
                           acc_in = bias_next;
                           state_in = ST_RUN;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            if (last_tap) begin
               state_in = ST_DRAIN;
            end else if (32'(tx_ff) + 1 < 32'(xc)) begin
               tx_in = tx_ff + 1'b1;
            end else begin
               tx_in = '0;
               if (tc_ff != 2'd2) begin
                  tc_in = tc_ff + 2'd1;
               end else begin
                  tc_in = '0;
                  tr_in = tr_ff + 2'd1;
                  lr_in = (lr_ff == 2'd2) ? 2'd0 : lr_ff + 2'd1;
               end
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = RSPW'({res, KSEL_BITS'(k_ff), POS_BITS'(bcol_ff),
                                    POS_BITS'(orow_ff)});
               rsp_last_in = (32'(k_ff) + 1 >= 32'(kc));
               if (32'(k_ff) + 1 < 32'(kc)) begin
                  k_in = k_ff + 1'b1;
                  tr_in = '0; tc_in = '0; tx_in = '0; lr_in = blr_ff;
                  acc_in = ACCW'($signed(bias_ff[k_ff + 1'b1])) <<< FRAC_BITS;
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         row_ff <= '0; col_ff <= '0; chan_ff <= '0; rm_ff <= '0;
         v1_ff <= 1'b0; v2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         height_ff <= CFG_BITS'(64);
         width_ff  <= CFG_BITS'(64);
         chans_ff  <= CFG_BITS'(1);
         kerns_ff  <= CFG_BITS'(1);
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         row_ff <= row_in; col_ff <= col_in; chan_ff <= chan_in; rm_ff <= rm_in;
         v1_ff <= v1_in; v2_ff <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (reg_idx_type'(csr_index))
               REG_HEIGHT:   height_ff <= csr_wdata;
               REG_WIDTH:    width_ff  <= csr_wdata;
               REG_CHANNELS: chans_ff  <= {3'b000, csr_wdata[3:0]};
               REG_KERNELS:  kerns_ff  <= {2'b00, csr_wdata[4:0]};
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in; tr_ff <= tr_in; tc_ff <= tc_in; tx_ff <= tx_in; lr_ff <= lr_in;
      blr_ff <= blr_in; bcol_ff <= bcol_in; orow_ff <= orow_in;
      acc_ff <= acc_in;
      prod_ff <= $signed(line_rdata) * $signed(wgt_rdata);
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (accept && cmd == CMD_BIAS && 32'(f_kern) < MAX_KERNELS) begin
         bias_ff[KW'(f_kern)] <= f_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule
